@@ src/mt_pkg.sv @@
// Shared types, constants and the output tempering function of the MT19937 generator.
`default_nettype none
package mt_pkg;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_LOAD   = 2'd1,
    OP_DRAW   = 2'd2
  } mt_op_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_FILL_A = 9'b000000010,
    ST_FILL_B = 9'b000000100,
    ST_TW_PRE = 9'b000001000,
    ST_TW_RA  = 9'b000010000,
    ST_TW_RM  = 9'b000100000,
    ST_TW_WR  = 9'b001000000,
    ST_DR_RD  = 9'b010000000,
    ST_DR_T   = 9'b100000000
  } mt_state_t;

  localparam logic [31:0] DEFAULT_SEED = 32'd4357;
  localparam logic [31:0] LCG_MUL      = 32'd69069;
  localparam logic [31:0] TWIST_XOR    = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;

  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

@@ src/mersenne_twister_generator.sv @@
// MT19937 generator: state memory, seed fill, in-place twist and tempered draws.
//
// Command interface: an item is taken when start is high and busy is low; a draw
// returns one tempered word on out_random_word, flagged by out_strobe for one cycle,
// which the receiver must take. Work per item, all bound by the single read port of
// the state memory and one shared 32x32 LCG multiplier: a load finishes in its accept
// cycle, a reseed keeps busy high while it fills every word (two LCG steps per word), a
// draw reads and tempers one word, preceded every STATE_WORDS draws by a regeneration
// pass (read next word, read offset word, write, for each word), and the very first
// draw after reset without a reseed adds a default-seed fill.
// The seed register may be written whenever busy is low.
`default_nettype none
module mersenne_twister_generator
  import mt_pkg::*;
#(
  parameter int STATE_WORDS  = 624,
  parameter int TWIST_OFFSET = 397
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [9:0]  in_word_index,
  input  wire logic [31:0] in_word_value,
  output logic             out_strobe,
  output logic [31:0]      out_random_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_seed_value
);

  localparam int RAW   = $clog2(STATE_WORDS);
  localparam int AW    = $clog2(STATE_WORDS + 2);
  localparam int SPLIT = STATE_WORDS - TWIST_OFFSET;
  localparam logic [AW-1:0] LAST_IDX     = AW'(STATE_WORDS - 1);
  localparam logic [AW-1:0] POS_REGEN    = AW'(STATE_WORDS);
  localparam logic [AW-1:0] POS_UNSEEDED = AW'(STATE_WORDS + 1);

  mt_state_t     state_r, state_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [31:0]   lcg_r, lcg_nxt;
  logic [15:0]   hi_r, hi_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   succ_r, succ_nxt;
  logic [31:0]   w0_r, w0_nxt;
  logic          draw_pend_r, draw_pend_nxt;
  logic [31:0]   seed_r, seed_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  logic [31:0]   out_word_r, out_word_nxt;

  logic            ram_we;
  logic [RAW-1:0]  ram_waddr;
  logic [31:0]     ram_wdata;
  logic [RAW-1:0]  ram_raddr;
  logic [31:0]     ram_rdata;

  logic [31:0]   lcg_step;
  logic [AW-1:0] k_offs;
  logic [AW-1:0] k_succ;
  logic [31:0]   mix_y;
  logic [31:0]   twist_word;
  logic          accept;

  mt_ram #(
    .WIDTH (32),
    .DEPTH (STATE_WORDS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = !busy;
  assign out_strobe      = out_strobe_r;
  assign out_random_word = out_word_r;
  assign accept          = start && !busy;

  // shared multiplier for the congruential fill
  assign lcg_step = 32'(lcg_r * LCG_MUL + 32'd1);

  assign k_offs = (k_r < AW'(SPLIT)) ? k_r + AW'(TWIST_OFFSET) : k_r - AW'(SPLIT);
  assign k_succ = (k_r == LAST_IDX) ? '0 : k_r + AW'(1);

  assign mix_y      = {cur_r[31], succ_r[30:0]};
  assign twist_word = ram_rdata ^ (mix_y >> 1) ^ (mix_y[0] ? TWIST_XOR : 32'd0);

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    pos_nxt        = pos_r;
    lcg_nxt        = lcg_r;
    hi_nxt         = hi_r;
    cur_nxt        = cur_r;
    succ_nxt       = succ_r;
    w0_nxt         = w0_r;
    draw_pend_nxt  = draw_pend_r;
    seed_nxt       = seed_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    ram_we         = 1'b0;
    ram_waddr      = k_r[RAW-1:0];
    ram_wdata      = twist_word;
    ram_raddr      = k_r[RAW-1:0];

    if (cfg_valid && cfg_ready) begin
      seed_nxt = cfg_seed_value;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_RESEED: begin
              lcg_nxt       = seed_r;
              k_nxt         = '0;
              draw_pend_nxt = 1'b0;
              state_nxt     = ST_FILL_A;
            end
            OP_LOAD: begin
              if (in_word_index < 10'(STATE_WORDS)) begin
                ram_we    = 1'b1;
                ram_waddr = in_word_index[RAW-1:0];
                ram_wdata = in_word_value;
                pos_nxt   = POS_REGEN;
              end
            end
            OP_DRAW: begin
              k_nxt = '0;
              if (pos_r == POS_UNSEEDED) begin
                lcg_nxt       = DEFAULT_SEED;
                draw_pend_nxt = 1'b1;
                state_nxt     = ST_FILL_A;
              end else if (pos_r == POS_REGEN) begin
                state_nxt = ST_TW_PRE;
              end else begin
                state_nxt = ST_DR_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL_A: begin
        hi_nxt    = lcg_r[31:16];
        lcg_nxt   = lcg_step;
        state_nxt = ST_FILL_B;
      end
      ST_FILL_B: begin
        ram_we    = 1'b1;
        ram_wdata = {hi_r, lcg_r[31:16]};
        lcg_nxt   = lcg_step;
        k_nxt     = k_r + AW'(1);
        state_nxt = ST_FILL_A;
        if (k_r == LAST_IDX) begin
          pos_nxt   = POS_REGEN;
          k_nxt     = '0;
          state_nxt = draw_pend_r ? ST_TW_PRE : ST_IDLE;
        end
      end
      ST_TW_PRE: begin
        ram_raddr = '0;
        state_nxt = ST_TW_RA;
      end
      ST_TW_RA: begin
        // word 0 comes back from the prefetch; later words roll over from succ_r
        if (k_r == '0) begin
          cur_nxt = ram_rdata;
        end
        ram_raddr = k_succ[RAW-1:0];
        state_nxt = ST_TW_RM;
      end
      ST_TW_RM: begin
        // last word mixes with the already twisted word 0
        succ_nxt  = (k_r == LAST_IDX) ? w0_r : ram_rdata;
        ram_raddr = k_offs[RAW-1:0];
        state_nxt = ST_TW_WR;
      end
      ST_TW_WR: begin
        ram_we  = 1'b1;
        cur_nxt = succ_r;
        if (k_r == '0) begin
          w0_nxt = twist_word;
        end
        k_nxt     = k_r + AW'(1);
        state_nxt = ST_TW_RA;
        if (k_r == LAST_IDX) begin
          pos_nxt   = '0;
          state_nxt = ST_DR_RD;
        end
      end
      ST_DR_RD: begin
        ram_raddr = pos_r[RAW-1:0];
        state_nxt = ST_DR_T;
      end
      ST_DR_T: begin
        out_word_nxt   = mt_temper(ram_rdata);
        out_strobe_nxt = 1'b1;
        pos_nxt        = pos_r + AW'(1);
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= POS_UNSEEDED;
      seed_r       <= DEFAULT_SEED;
      out_strobe_r <= 1'b0;
      draw_pend_r  <= 1'b0;
      k_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      seed_r       <= seed_nxt;
      out_strobe_r <= out_strobe_nxt;
      draw_pend_r  <= draw_pend_nxt;
      k_r          <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lcg_r      <= lcg_nxt;
    hi_r       <= hi_nxt;
    cur_r      <= cur_nxt;
    succ_r     <= succ_nxt;
    w0_r       <= w0_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule
`default_nettype wire

@@ src/mt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module mt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/mt_checker.sv @@
// Port-level checker for the MT19937 generator, bound to the top level.
`default_nettype none
module mt_checker
  import mt_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_operation,
  input wire logic       out_strobe
);

  // a word never shows up back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("out_strobe high on two consecutive cycles");

  // only a draw produces a word
  a_no_word_for_other_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != OP_DRAW) |=> !out_strobe)
    else $error("word produced by a non-draw command");

  // a draw always occupies the block
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_DRAW) |=> busy)
    else $error("draw accepted without going busy");

  // the word comes out as the block returns to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("out_strobe while busy");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("busy or strobe after reset");

endmodule

bind mersenne_twister_generator mt_checker u_mt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_operation (in_operation),
  .out_strobe   (out_strobe)
);
`default_nettype wire
